// ===== hdl/fds_pkg.sv =====
package fds_pkg;

    localparam int KEY_W = 32;
    localparam int LEN_W = 7;
    localparam int IDX_W = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // key sits in the low bits so the record packs straight into tdata
    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic [LEN_W-1:0]        len;
        logic signed [KEY_W-1:0] key;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_FIRST,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic fetch;
        logic first;
        logic issue;
        logic scan;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic load_last;
        logic i_last;
        logic j_done;
        logic out_full;
    } dp_stat_t;

endpackage

// ===== hdl/fds_ctrl.sv =====
module fds_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  fds_pkg::dp_stat_t stat,
    output fds_pkg::dp_cmd_t  cmd
);

    fds_pkg::state_t state_reg;
    fds_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fds_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            fds_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_wr = 1'b1;
                    if (stat.load_last) begin
                        state_next = fds_pkg::ST_FETCH;
                    end
                end
            end
            fds_pkg::ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = fds_pkg::ST_FIRST;
            end
            fds_pkg::ST_FIRST: begin
                cmd.first = 1'b1;
                if (stat.i_last) begin
                    state_next = fds_pkg::ST_EMIT;
                end else begin
                    cmd.issue  = 1'b1;
                    state_next = fds_pkg::ST_SCAN;
                end
            end
            fds_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.j_done) begin
                    state_next = fds_pkg::ST_EMIT;
                end else begin
                    cmd.issue = 1'b1;
                end
            end
            fds_pkg::ST_EMIT: begin
                if (!stat.out_full) begin
                    cmd.emit = 1'b1;
                    if (stat.i_last) begin
                        state_next = fds_pkg::ST_LOAD;
                    end else begin
                        state_next = fds_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = fds_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

// ===== hdl/fds_datapath.sv =====
module fds_datapath #(
    parameter int ENTRIES = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [fds_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fds_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  fds_pkg::dp_cmd_t                 cmd,
    output fds_pkg::dp_stat_t                stat
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    fds_pkg::rec_t mem [ENTRIES];

    logic [CW-1:0]   load_cnt_reg;
    logic [AW-1:0]   i_reg;
    logic [CW-1:0]   j_reg;
    logic [AW-1:0]   rd_addr_reg;
    fds_pkg::rec_t   rd_data_reg;
    fds_pkg::rec_t   cur_reg;
    fds_pkg::rec_t   out_rec_reg;
    logic            out_last_reg;
    logic            m_tvalid_reg;

    logic            less;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    fds_pkg::rec_t   wr_rec;
    fds_pkg::rec_t   in_rec;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    assign in_rec.key = s_tdata[fds_pkg::KEY_W-1:0];
    assign in_rec.len = s_tdata[fds_pkg::KEY_W+fds_pkg::LEN_W-1:fds_pkg::KEY_W];
    assign in_rec.idx = fds_pkg::IDX_W'(load_cnt_reg);

    assign less    = cur_reg.key < rd_data_reg.key;
    assign wr_en   = cmd.load_wr | (cmd.scan & less);
    assign wr_addr = cmd.load_wr ? load_cnt_reg[AW-1:0] : rd_addr_reg;
    assign wr_rec  = cmd.load_wr ? in_rec : cur_reg;
    assign rd_en   = cmd.fetch | cmd.issue;
    assign rd_addr = cmd.fetch ? i_reg : j_reg[AW-1:0];

    assign stat.load_last = load_cnt_reg == CW'(ENTRIES - 1);
    assign stat.i_last    = i_reg == AW'(ENTRIES - 1);
    assign stat.j_done    = j_reg == CW'(ENTRIES);
    assign stat.out_full  = m_tvalid_reg & ~m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(fds_pkg::M_TDATA_W - fds_pkg::REC_W)'(0), out_rec_reg};
    assign m_tlast  = out_last_reg;

    // record store, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_rec;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // running winner for the current position
    always_ff @(posedge aclk) begin
        if (cmd.first || (cmd.scan && less)) begin
            cur_reg <= rd_data_reg;
        end
        if (cmd.emit) begin
            out_rec_reg  <= cur_reg;
            out_last_reg <= stat.i_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_wr) begin
                load_cnt_reg <= stat.load_last ? '0 : load_cnt_reg + CW'(1);
            end
            if (cmd.fetch) begin
                j_reg <= CW'(i_reg) + CW'(1);
            end else if (cmd.issue) begin
                j_reg <= j_reg + CW'(1);
            end
            if (cmd.emit) begin
                i_reg        <= stat.i_last ? '0 : i_reg + AW'(1);
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/fitness_descending_sorter_core.sv =====
// sequence: ENTRIES load words at one per cycle while s_tvalid is high, then per
// output position i: fetch, first read, one compare per later entry, emit
// the single read port of the record store sets the one-compare-per-cycle pace
// reset: synchronous active-low aresetn clears the load count, position counters,
// controller state and output valid; record store contents are not cleared
module fitness_descending_sorter_core #(
    parameter int ENTRIES = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fds_pkg::S_TDATA_W-1:0] s_tdata,  // fitness_key, path_length
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fds_pkg::M_TDATA_W-1:0] m_tdata,  // sorted_key, sorted_length, source_index
    output logic                          m_tlast
);

    fds_pkg::dp_cmd_t  cmd;
    fds_pkg::dp_stat_t stat;

    fds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fds_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== hdl/fds_checker.sv =====
module fds_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fds_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    logic signed [fds_pkg::KEY_W-1:0] prev_key_reg;
    logic                             in_run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            in_run_reg <= ~m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            prev_key_reg <= m_tdata[fds_pkg::KEY_W-1:0];
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_descending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && in_run_reg
            |-> $signed(m_tdata[fds_pkg::KEY_W-1:0]) <= prev_key_reg)
        else $error("output keys not descending");

    a_load_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input closed without a load");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) |-> m_tvalid && m_tlast)
        else $error("input reopened before last word");

endmodule

bind fitness_descending_sorter_core fds_checker u_fds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
